@@ rtl/mrtw_pkg.sv @@
package mrtw_pkg;

   localparam int DEF_MAX_POINTS  = 64;
   localparam int DEF_SAMPLE_BITS = 16;

   localparam int IDX_BITS = 6;
   localparam int LEN_BITS = 7;

   localparam logic [LEN_BITS-1:0] RESET_POINTS = 7'd64;

   typedef struct packed {
      logic                wr;
      logic                sum_clr;
      logic                div_go;
      logic                div_mean;
      logic                mean_ld;
      logic                rd;
      logic                diff_ld;
      logic                prod_ld;
      logic                res_ld;
      logic [IDX_BITS-1:0] idx;
      logic [LEN_BITS-1:0] len;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
   } ctrl_status_type;

endpackage

@@ rtl/mrtw_ifs.sv @@
interface mrtw_req_if import mrtw_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface mrtw_rsp_if import mrtw_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_BITS:0] windowed_value;
   logic [IDX_BITS-1:0]         sample_index;
   logic                        frame_last;

   modport source (output valid, output windowed_value, output sample_index,
                   output frame_last, input ready);
   modport sink   (input valid, input windowed_value, input sample_index,
                   input frame_last, output ready);
endinterface

@@ rtl/mean_removed_triangular_window.sv @@
// The block takes a frame of signed samples on the request channel, one item
// per cycle, while it stores each sample and adds it to a running sum.
// The frame length comes from the csr port; the user is to write it only while idle,
// which the block does not enforce. A length of zero acts as one, and a length above
// MAX_POINTS acts as MAX_POINTS. After the last sample of a frame the request channel
// is not ready until the last result of that frame has been formed.
// The mean is formed after the last sample by a shared one-bit-per-cycle divider.
// Each result is then formed in steps: a sample read, the subtraction of the
// mean, one multiply by the triangular weight and a pass through the same divider.
// The response channel holds each result in registers. A stalled receiver
// holds back the next result of the frame until the item is taken, while the
// next frame can already be collected behind the last result of a frame.
// Reset clears the frame in progress and sets the frame length to 64.
module mean_removed_triangular_window import mrtw_pkg::*; #(
   parameter int MAX_POINTS  = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LEN_BITS-1:0] csr_wr_data,
   mrtw_req_if.sink            req_ch,
   mrtw_rsp_if.source          rsp_ch
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   mrtw_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_index   (rsp_ch.sample_index),
      .rsp_last    (rsp_ch.frame_last),
      .cmd         (cmd),
      .status      (status)
   );

   mrtw_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .sample         (req_ch.sample),
      .cmd            (cmd),
      .status         (status),
      .windowed_value (rsp_ch.windowed_value)
   );

endmodule

@@ rtl/mrtw_div.sv @@
module mrtw_div import mrtw_pkg::*; #(
   parameter int DIV_BITS = DEF_SAMPLE_BITS + 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [LEN_BITS-1:0] divisor,
   output logic [DIV_BITS-1:0] quotient,
   output logic                done
);

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS-1:0] quot_ff, quot_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [LEN_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [LEN_BITS:0]   shifted;
   logic [LEN_BITS:0]   trial;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quot_ff[DIV_BITS-1]};
      trial   = shifted - {1'b0, dvs_ff};
      fits    = shifted >= {1'b0, dvs_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (go) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
         quot_in = {quot_ff[DIV_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

@@ rtl/mrtw_ctrl.sv @@
module mrtw_ctrl import mrtw_pkg::*; #(
   parameter int MAX_POINTS = DEF_MAX_POINTS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [LEN_BITS-1:0] csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [IDX_BITS-1:0] rsp_index,
   output logic                rsp_last,
   output ctrl_cmd_type        cmd,
   input  ctrl_status_type     status
);

   localparam logic [LEN_BITS-1:0] MaxLen = LEN_BITS'(MAX_POINTS);

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_READ,
      ST_DIFF,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_BITS-1:0] num_points_ff, num_points_in;
   logic [LEN_BITS-1:0] fill_ff, fill_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [IDX_BITS-1:0] n_ff, n_in;
   logic [IDX_BITS-1:0] out_idx_ff, out_idx_in;
   logic                last_ff, last_in;
   logic                req_ready_ff, req_ready_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0] eff_len;
   logic [LEN_BITS-1:0] fill_next;
   logic                accept;

   always_comb begin
      if (num_points_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (num_points_ff > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = num_points_ff;
      end
   end

   assign accept    = req_valid & req_ready_ff;
   assign fill_next = fill_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      num_points_in = csr_wr_en ? csr_wr_data : num_points_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      n_in          = n_ff;
      out_idx_in    = out_idx_ff;
      last_in       = last_ff;
      req_ready_in  = req_ready_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd           = '0;
      cmd.idx       = n_ff;
      cmd.len       = len_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_COLLECT: begin
            cmd.idx = fill_ff[IDX_BITS-1:0];
            if (accept) begin
               cmd.wr  = 1'b1;
               fill_in = fill_next;
               if (fill_next >= eff_len) begin
                  len_in       = fill_next;
                  req_ready_in = 1'b0;
                  state_in     = ST_MEAN_GO;
               end
            end
         end
         ST_MEAN_GO: begin
            cmd.div_go   = 1'b1;
            cmd.div_mean = 1'b1;
            state_in     = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.mean_ld = 1'b1;
               cmd.sum_clr = 1'b1;
               fill_in     = '0;
               n_in        = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff) begin
               cmd.rd   = 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff_ld = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.prod_ld = 1'b1;
            state_in    = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.res_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               out_idx_in   = n_ff;
               last_in      = ({1'b0, n_ff} == (len_ff - 1'b1));
               if (last_in) begin
                  req_ready_in = 1'b1;
                  state_in     = ST_COLLECT;
               end else begin
                  n_in     = n_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            req_ready_in = 1'b1;
            rsp_valid_in = 1'b0;
            fill_in      = '0;
            state_in     = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      n_ff       <= n_in;
      out_idx_ff <= out_idx_in;
      last_ff    <= last_in;
      if (reset) begin
         state_ff      <= ST_COLLECT;
         num_points_ff <= RESET_POINTS;
         fill_ff       <= '0;
         req_ready_ff  <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         num_points_ff <= num_points_in;
         fill_ff       <= fill_in;
         req_ready_ff  <= req_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = out_idx_ff;
   assign rsp_last  = last_ff;

endmodule

@@ rtl/mrtw_dp.sv @@
module mrtw_dp import mrtw_pkg::*; #(
   parameter int MAX_POINTS  = DEF_MAX_POINTS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  ctrl_cmd_type                  cmd,
   output ctrl_status_type               status,
   output logic signed [SAMPLE_BITS:0]   windowed_value
);

   localparam int ADDR_BITS = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int DIV_BITS  = SAMPLE_BITS + 7;
   localparam int PROD_BITS = SAMPLE_BITS + 10;

   logic [SAMPLE_BITS-1:0]        store_mem [MAX_POINTS];
   logic [SAMPLE_BITS-1:0]        rd_data_ff;
   logic signed [DIV_BITS-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_BITS:0]   mean_ff, mean_in;
   logic signed [SAMPLE_BITS:0]   diff_ff, diff_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [SAMPLE_BITS:0]   res_ff, res_in;
   logic                          neg_ff, neg_in;
   logic signed [7:0]             delta;
   logic [LEN_BITS-1:0]           abs_dist;
   logic [7:0]                    weight;
   logic [DIV_BITS-1:0]           dividend;
   logic [LEN_BITS-1:0]           divisor;
   logic [DIV_BITS-1:0]           quotient;
   logic [DIV_BITS-1:0]           signed_quot;
   logic [PROD_BITS-1:0]          prod_mag;
   logic                          div_done;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         store_mem[cmd.idx[ADDR_BITS-1:0]] <= sample;
      end
      if (cmd.rd) begin
         rd_data_ff <= store_mem[cmd.idx[ADDR_BITS-1:0]];
      end
   end

   always_comb begin
      delta    = $signed({1'b0, cmd.idx, 1'b0}) - $signed({1'b0, cmd.len}) + 8'sd1;
      abs_dist = delta[7] ? LEN_BITS'(-delta) : delta[LEN_BITS-1:0];
      weight   = {1'b0, cmd.len} + 8'd1 - {1'b0, abs_dist};
      prod_mag = prod_ff[PROD_BITS-1] ? PROD_BITS'(-prod_ff) : prod_ff;
      signed_quot = neg_ff ? DIV_BITS'(-quotient) : quotient;

      sum_in = sum_ff;
      if (cmd.sum_clr) begin
         sum_in = '0;
      end else if (cmd.wr) begin
         sum_in = sum_ff + DIV_BITS'(sample);
      end

      mean_in = cmd.mean_ld ? signed_quot[SAMPLE_BITS:0] : mean_ff;
      diff_in = cmd.diff_ld
              ? ($signed({rd_data_ff[SAMPLE_BITS-1], rd_data_ff}) - mean_ff) : diff_ff;
      prod_in = cmd.prod_ld ? (diff_ff * $signed({1'b0, weight})) : prod_ff;
      res_in  = cmd.res_ld ? signed_quot[SAMPLE_BITS:0] : res_ff;

      neg_in   = neg_ff;
      dividend = prod_mag[DIV_BITS-1:0];
      divisor  = cmd.len + 1'b1;
      if (cmd.div_mean) begin
         dividend = sum_ff[DIV_BITS-1] ? DIV_BITS'(-sum_ff) : sum_ff;
         divisor  = cmd.len;
      end
      if (cmd.div_go) begin
         neg_in = cmd.div_mean ? sum_ff[DIV_BITS-1] : prod_ff[PROD_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      neg_ff  <= neg_in;
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   mrtw_div #(
      .DIV_BITS (DIV_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (dividend),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.div_done = div_done;
   assign windowed_value  = res_ff;

endmodule

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mrtw_pkg::*;

   localparam int     SAMPLE_W            = DEF_SAMPLE_BITS;
   localparam int     RESULT_W            = SAMPLE_W + 1;
   localparam int     FRAME_MAX           = DEF_MAX_POINTS;
   localparam int     TARGET_SAMPLES      = 280;
   localparam int     SETTLE_CYCLES       = 60;
   localparam int     BACKPRESSURE_CYCLES = 400;
   localparam longint CYCLE_LIMIT         = 400000;
   localparam int     MAX_REPORTS         = 20;

   typedef struct {
      logic signed [RESULT_W-1:0] value;
      logic [IDX_BITS-1:0]        index;
      logic                       last;
   } window_result_type;

   class window_tracker_type;
      logic [LEN_BITS-1:0] length_reg;
      longint              frame_samples[FRAME_MAX];
      longint              frame_sum;
      int                  frame_fill;
      window_result_type   windowed_due[$];
      int                  mismatches;
      int                  results_seen;
      int                  frames_closed;

      function new();
         length_reg    = RESET_POINTS;
         frame_sum     = 0;
         frame_fill    = 0;
         mismatches    = 0;
         results_seen  = 0;
         frames_closed = 0;
      endfunction

      function void write_length(logic [LEN_BITS-1:0] v);
         length_reg = v;
      endfunction

      function void take_sample(logic signed [SAMPLE_W-1:0] x);
         int                eff;
         longint            mean;
         longint            denom;
         longint            delta;
         longint            wt;
         longint            v;
         window_result_type r;
         eff = (length_reg == 0) ? 1 : ((length_reg > FRAME_MAX) ? FRAME_MAX : length_reg);
         frame_samples[frame_fill] = x;
         frame_sum += x;
         frame_fill++;
         if (frame_fill < eff) return;
         mean  = frame_sum / frame_fill;
         denom = frame_fill + 1;
         for (int n = 0; n < frame_fill; n++) begin
            delta = 2 * n - (frame_fill - 1);
            if (delta < 0) delta = -delta;
            wt = denom - delta;
            v  = ((frame_samples[n] - mean) * wt) / denom;
            r.value = v[RESULT_W-1:0];
            r.index = IDX_BITS'(n);
            r.last  = (n == frame_fill - 1);
            windowed_due.push_back(r);
         end
         frame_sum  = 0;
         frame_fill = 0;
         frames_closed++;
      endfunction

      function void check_windowed(logic signed [RESULT_W-1:0] value,
                                   logic [IDX_BITS-1:0] index, logic last);
         window_result_type want;
         results_seen++;
         if (windowed_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none,", $time,
                        " got value %0d index %0d last %0b", value, index, last);
            return;
         end
         want = windowed_due.pop_front();
         if (value !== want.value || index !== want.index || last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result mismatch,", $time,
                        " expected value %0d index %0d last %0b,",
                        want.value, want.index, want.last,
                        " got value %0d index %0d last %0b", value, index, last);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [LEN_BITS-1:0] csr_wr_data;
   longint              cycle_count;
   bit                  steady_phase;
   int                  backpressure_hold;
   int                  samples_sent;
   int                  length_writes;
   window_tracker_type  tracker;

   mrtw_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_if ();
   mrtw_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_if ();

   mean_removed_triangular_window #(
      .MAX_POINTS (FRAME_MAX),
      .SAMPLE_BITS(SAMPLE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int draw_wait();
      return steady_phase ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int small_val;
      case ($urandom_range(0, 7))
         0: return {1'b0, {(SAMPLE_W-1){1'b1}}};
         1: return {1'b1, {(SAMPLE_W-1){1'b0}}};
         2: begin
            small_val = int'($urandom_range(0, 200)) - 100;
            return SAMPLE_W'(small_val);
         end
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Entered and left at a falling edge.
   task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= x;
      do @(posedge clock); while (!req_if.ready);
      tracker.take_sample(x);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic write_length(logic [LEN_BITS-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tracker.write_length(v);
      length_writes++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (tracker.windowed_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_frame(logic [LEN_BITS-1:0] len, logic signed [SAMPLE_W-1:0] a,
                             logic signed [SAMPLE_W-1:0] b, int count);
      write_length(len);
      for (int i = 0; i < count; i++) send_sample((i % 2 == 0) ? a : b);
      drain_results();
   endtask

   initial begin
      logic [LEN_BITS-1:0] len_val;
      int                  eff;
      int                  count;
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_if.valid      = 1'b0;
      req_if.sample     = '0;
      cycle_count       = 0;
      steady_phase      = 1'b0;
      backpressure_hold = 0;
      samples_sent      = 0;
      length_writes     = 0;
      tracker           = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fixed lengths from zero to four; zero length acts as one, so with it every item closes its own frame.
      send_frame(7'd0, 16'sh7FFF, 16'sh8000, 2);
      send_frame(7'd1, 16'sh0000, -16'sd1, 2);
      send_frame(7'd2, 16'sh7FFF, 16'sh8000, 2);
      send_frame(7'd3, 16'sh8000, 16'sh8000, 3);
      send_frame(7'd4, 16'sh7FFF, 16'sh8000, 4);

      // Lowering the length below the samples already held closes the frame early.
      write_length(7'd8);
      send_sample(16'sd5);
      send_sample(-16'sd7);
      send_sample(16'sd100);
      drain_results();
      write_length(7'd2);
      send_sample(16'sd9);
      drain_results();

      // The receiver holds off for a long stretch while four full frames of samples are offered.
      write_length(7'd8);
      backpressure_hold = BACKPRESSURE_CYCLES;
      repeat (32) send_sample(pick_sample());
      drain_results();

      while (samples_sent < TARGET_SAMPLES) begin
         case ($urandom_range(0, 19))
            0:       len_val = 7'd0;
            1:       len_val = 7'd127;
            2:       len_val = LEN_BITS'($urandom_range(65, 127));
            3:       len_val = 7'd64;
            default: len_val = LEN_BITS'($urandom_range(1, 12));
         endcase
         eff   = (len_val == 0) ? 1 : ((len_val > FRAME_MAX) ? FRAME_MAX : len_val);
         count = eff * ((eff > 16) ? 1 : $urandom_range(1, 3));
         if ($urandom_range(0, 4) == 0) count += $urandom_range(0, eff - 1);
         steady_phase = ($urandom_range(0, 3) == 0);
         write_length(len_val);
         repeat (count) send_sample(pick_sample());
         drain_results();
      end
      steady_phase = 1'b0;
      repeat (100) @(negedge clock);

      $display("Run covered %0d samples in %0d closed frames over %0d length settings.",
               samples_sent, tracker.frames_closed, length_writes);
      $display("Short fixed lengths, an early frame close and a long receiver stall came first; %0d results checked.",
               tracker.results_seen);
      if (tracker.mismatches == 0 && tracker.windowed_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = draw_wait();
         if (backpressure_hold > 0) begin
            stall = backpressure_hold;
            backpressure_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         tracker.check_windowed(rsp_if.windowed_value, rsp_if.sample_index,
                                rsp_if.frame_last);
         @(negedge clock);
      end
   end

endmodule
